[hdl/modbus_rtu_word_transaction_framer_assert.svh]
// Assertion macros for the Modbus RTU word framer.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef MODBUS_RTU_WORD_TRANSACTION_FRAMER_ASSERT_SVH
`define MODBUS_RTU_WORD_TRANSACTION_FRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBRTU_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBRTU_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mbrtu_pkg.sv]
// Shared types, codes and constants for the Modbus RTU word framer.
// No dependencies; every module in the project imports this package.
package mbrtu_pkg;

	localparam int unsigned RCNT_W            = 6;
	localparam int unsigned MAX_READ_RESPONSE = 32;
	localparam int unsigned QUEUE_DEPTH       = 4;
	localparam int unsigned QPTR_W            = $clog2(QUEUE_DEPTH);
	localparam int unsigned IDX_W             = 4;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  FUNC_READ  = 8'h03;
	localparam logic [7:0]  FUNC_WRITE = 8'h10;
	localparam logic [7:0]  BYTE_COUNT = 8'h04;
	localparam logic [7:0]  REG_COUNT  = 8'h02;

	localparam logic [RCNT_W-1:0] WRITE_CAP = RCNT_W'(8);
	localparam logic [RCNT_W-1:0] READ_MIN  = RCNT_W'(9);

	// Frame byte positions.
	localparam logic [IDX_W-1:0] READ_LAST_IDX  = IDX_W'(7);
	localparam logic [IDX_W-1:0] WRITE_LAST_IDX = IDX_W'(12);

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_RX_BYTE = 2'd2,
		CMD_CLOSE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_READ,
		OP_WRITE,
		OP_RX,
		OP_CLOSE
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_CRC_BAD  = 2'd2,
		ST_NO_ACK   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_TX      = 1'b0,
		KIND_VERDICT = 1'b1
	} result_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_SEND
	} back_state_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  unit_id;
		logic [15:0] reg_address;
		logic [31:0] data;
	} op_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[hdl/mbrtu_ifs.sv]
// Channel interfaces of the Modbus RTU word framer: command items in, results out.
// Standalone; valid/ready handshake, a beat moves when both are high.
interface mbrtu_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  unit_id;
	logic [15:0] reg_address;
	logic [31:0] write_value;
	logic [7:0]  rx_byte;

	modport source(output valid, cmd, unit_id, reg_address, write_value, rx_byte,
		input ready);
	modport sink(input valid, cmd, unit_id, reg_address, write_value, rx_byte,
		output ready);
endinterface

interface mbrtu_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic [1:0]  status;
	logic [31:0] read_value;

	modport source(output valid, result_kind, tx_byte, tx_last, status, read_value,
		input ready);
	modport sink(input valid, result_kind, tx_byte, tx_last, status, read_value,
		output ready);
endinterface

[hdl/mbrtu_front.sv]
// Front end: accepts command beats, classifies them into operations.
// Depends on mbrtu_pkg and mbrtu_item_if; feeds mbrtu_queue.
module mbrtu_front
	import mbrtu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mbrtu_item_if.sink    item,
	output logic          push,
	output op_t           push_op,
	input  logic          push_ready
);

	logic valid_s1;
	op_t  op_s1;
	op_t  op_d;

	assign item.ready = !valid_s1 || push_ready;
	assign push       = valid_s1;
	assign push_op    = op_s1;

	always_comb begin
		op_d.unit_id     = item.unit_id;
		op_d.reg_address = item.reg_address;
		op_d.data        = item.write_value;
		unique case (cmd_t'(item.cmd))
			CMD_READ:    op_d.kind = OP_READ;
			CMD_WRITE:   op_d.kind = OP_WRITE;
			CMD_RX_BYTE: begin
				op_d.kind = OP_RX;
				op_d.data = {24'h000000, item.rx_byte};
			end
			CMD_CLOSE:   op_d.kind = OP_CLOSE;
			default:     op_d.kind = OP_CLOSE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1 <= op_d;
		end
	end

endmodule

[hdl/mbrtu_queue.sv]
// Short operation queue between the front end and the back end.
// Depends on mbrtu_pkg for op_t and depth constants.
module mbrtu_queue
	import mbrtu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic push_ready,
	output logic pop_valid,
	output op_t  pop_op,
	input  logic pop
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[hdl/mbrtu_back.sv]
// Back end: builds request frames with CRC, tracks the response, issues verdicts.
// Depends on mbrtu_pkg and mbrtu_result_if; drains mbrtu_queue.
module mbrtu_back
	import mbrtu_pkg::*;
#(
	parameter int unsigned MAX_READ_RESPONSE = mbrtu_pkg::MAX_READ_RESPONSE
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  op_t             op,
	output logic            pop,
	mbrtu_result_if.source  result
);

	localparam logic [RCNT_W-1:0] READ_CAP = RCNT_W'(MAX_READ_RESPONSE);

	back_state_t state_q, state_d;

	// Request being sent
	logic [7:0]       sid_q;
	logic [15:0]      addr_q;
	logic [31:0]      wv_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      tx_crc_q;

	// Response tracking
	logic              is_write_q;
	logic [RCNT_W-1:0] rcount_q;
	logic [15:0]       rx_crc_q;
	logic [15:0]       held_q;
	logic [7:0]        func_q;
	logic [31:0]       word_q;

	// Output register
	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_value_q;

	logic        out_free;
	logic        out_load;
	logic        start_req;
	logic        rx_take;
	logic        tx_step;
	logic        tx_is_crc;
	logic        tx_is_last;
	logic [7:0]  tx_data;
	logic [7:0]  tx_byte_d;
	status_t     verdict;
	logic [31:0] verdict_value;
	result_kind_t out_kind_d;
	logic [7:0]  out_byte_d;
	logic        out_last_d;
	status_t     out_status_d;
	logic [31:0] out_value_d;
	logic [RCNT_W-1:0] rx_cap;
	logic [7:0]  rx_b;

	assign out_free = !out_valid_q || result.ready;
	assign rx_cap   = is_write_q ? WRITE_CAP : READ_CAP;
	assign rx_b     = op.data[7:0];

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.tx_byte     = out_byte_q;
	assign result.tx_last     = out_last_q;
	assign result.status      = out_status_q;
	assign result.read_value  = out_value_q;

	// Frame byte at the current position
	always_comb begin
		tx_is_last = idx_q == (is_write_q ? WRITE_LAST_IDX : READ_LAST_IDX);
		tx_is_crc  = idx_q >= (is_write_q ? WRITE_LAST_IDX - 1'b1 : READ_LAST_IDX - 1'b1);
		case (idx_q)
			IDX_W'(0): tx_data = sid_q;
			IDX_W'(1): tx_data = is_write_q ? FUNC_WRITE : FUNC_READ;
			IDX_W'(2): tx_data = addr_q[15:8];
			IDX_W'(3): tx_data = addr_q[7:0];
			IDX_W'(4): tx_data = 8'h00;
			IDX_W'(5): tx_data = REG_COUNT;
			IDX_W'(6): tx_data = BYTE_COUNT;
			IDX_W'(7): tx_data = wv_q[31:24];
			IDX_W'(8): tx_data = wv_q[23:16];
			IDX_W'(9): tx_data = wv_q[15:8];
			IDX_W'(10): tx_data = wv_q[7:0];
			default:   tx_data = 8'h00;
		endcase
		if (tx_is_crc) begin
			tx_byte_d = tx_is_last ? tx_crc_q[15:8] : tx_crc_q[7:0];
		end else begin
			tx_byte_d = tx_data;
		end
	end

	// Verdict from the response state
	always_comb begin
		verdict_value = 32'h0;
		if (is_write_q) begin
			if (rcount_q < WRITE_CAP) begin
				verdict = ST_SHORT;
			end else if (func_q != FUNC_WRITE) begin
				verdict = ST_NO_ACK;
			end else begin
				verdict = ST_OK;
			end
		end else begin
			if (rcount_q < READ_MIN) begin
				verdict = ST_SHORT;
			end else if (held_q != {rx_crc_q[7:0], rx_crc_q[15:8]}) begin
				verdict = ST_CRC_BAD;
			end else begin
				verdict       = ST_OK;
				verdict_value = word_q;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		pop          = 1'b0;
		out_load     = 1'b0;
		start_req    = 1'b0;
		rx_take      = 1'b0;
		tx_step      = 1'b0;
		out_kind_d   = KIND_TX;
		out_byte_d   = 8'h00;
		out_last_d   = 1'b0;
		out_status_d = ST_OK;
		out_value_d  = 32'h0;
		unique case (state_q)
			BK_IDLE: begin
				if (op_valid) begin
					unique case (op.kind) inside
						OP_READ, OP_WRITE: begin
							pop       = 1'b1;
							start_req = 1'b1;
							state_d   = BK_SEND;
						end
						OP_RX: begin
							pop     = 1'b1;
							rx_take = 1'b1;
						end
						OP_CLOSE: begin
							if (out_free) begin
								pop          = 1'b1;
								out_load     = 1'b1;
								out_kind_d   = KIND_VERDICT;
								out_last_d   = 1'b1;
								out_status_d = verdict;
								out_value_d  = verdict_value;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			BK_SEND: begin
				if (out_free) begin
					out_load   = 1'b1;
					tx_step    = 1'b1;
					out_byte_d = tx_byte_d;
					out_last_d = tx_is_last;
					if (tx_is_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_write_q <= 1'b0;
			rcount_q   <= '0;
			rx_crc_q   <= CRC_INIT;
			held_q     <= 16'h0;
			func_q     <= 8'h00;
			word_q     <= 32'h0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_req) begin
				is_write_q <= op.kind == OP_WRITE;
				rcount_q   <= '0;
				rx_crc_q   <= CRC_INIT;
				held_q     <= 16'h0;
				func_q     <= 8'h00;
				word_q     <= 32'h0;
			end else if (rx_take && rcount_q < rx_cap) begin
				// the last two bytes stay out of the CRC until a third arrives
				if (rcount_q >= RCNT_W'(2)) begin
					rx_crc_q <= crc_feed(rx_crc_q, held_q[15:8]);
				end
				held_q <= {held_q[7:0], rx_b};
				if (rcount_q == RCNT_W'(1)) begin
					func_q <= rx_b;
				end
				if (rcount_q >= RCNT_W'(3) && rcount_q <= RCNT_W'(6)) begin
					word_q <= {word_q[23:0], rx_b};
				end
				rcount_q <= rcount_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_req) begin
			sid_q    <= op.unit_id;
			addr_q   <= op.reg_address;
			wv_q     <= op.data;
			idx_q    <= '0;
			tx_crc_q <= CRC_INIT;
		end else if (tx_step) begin
			idx_q <= idx_q + 1'b1;
			if (!tx_is_crc) begin
				tx_crc_q <= crc_feed(tx_crc_q, tx_data);
			end
		end
		if (out_load) begin
			out_kind_q   <= out_kind_d;
			out_byte_q   <= out_byte_d;
			out_last_q   <= out_last_d;
			out_status_q <= out_status_d;
			out_value_q  <= out_value_d;
		end
	end

endmodule

[hdl/modbus_rtu_word_transaction_framer.sv]
// Modbus RTU word framer, top level: front end, operation queue, back end.
// Response and close beats are taken one a cycle while the queue has room;
// each is registered in the front stage, then queued. A read request yields 8 byte beats,
// a write 13, one a cycle while the output register is free; the back end handles one
// request frame at a time; a verdict follows each close beat. Reset clears all control and
// response state asynchronously; the block is ready once reset is released.
`include "modbus_rtu_word_transaction_framer_assert.svh"

module modbus_rtu_word_transaction_framer
	import mbrtu_pkg::*;
#(
	parameter int unsigned MAX_READ_RESPONSE = mbrtu_pkg::MAX_READ_RESPONSE
) (
	input  logic           clk,
	input  logic           arst_n,
	mbrtu_item_if.sink     item,
	mbrtu_result_if.source result
);

	logic push;
	op_t  push_op;
	logic push_ready;
	logic pop_valid;
	op_t  pop_op;
	logic pop;

	mbrtu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	mbrtu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop        (pop)
	);

	mbrtu_back #(
		.MAX_READ_RESPONSE (MAX_READ_RESPONSE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (pop_valid),
		.op       (pop_op),
		.pop      (pop),
		.result   (result)
	);

	`MBRTU_HOLDS(a_verdict_last, result.valid && result.result_kind == KIND_VERDICT, result.tx_last, "verdict without last flag")
	`MBRTU_HOLDS(a_tx_clean, result.valid && result.result_kind == KIND_TX, result.status == ST_OK && result.read_value == 32'h0, "request beat carries verdict data")
	`MBRTU_NEXT(a_front_holds, push && !push_ready, push, "front stage dropped a beat")
	`MBRTU_HOLDS(a_pop_nonempty, pop, pop_valid, "pop from empty queue")

endmodule

[bench/mbrtu_frame_monitor.sv]
// Monitor for the Modbus RTU word framer: watches the command and result channels.
// Works out the request bytes and verdicts owed for each command beat and checks them.
// Depends on mbrtu_pkg and the channel interfaces in hdl/mbrtu_ifs.sv.
module mbrtu_frame_monitor
	import mbrtu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mbrtu_item_if       item_ch,
	mbrtu_result_if     result_ch,
	output int unsigned pending,
	output int unsigned failures
);

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   tx_byte;
		logic         tx_last;
		status_t      status;
		logic [31:0]  read_value;
	} framer_beat_t;

	framer_beat_t      owed_results[$];
	logic              write_txn;
	logic [RCNT_W-1:0] rx_count;
	logic [15:0]       rx_crc;
	logic [15:0]       rx_tail;
	logic [7:0]        rx_func;
	logic [31:0]       rx_word;

	function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	task automatic apply_command(input cmd_t c, input logic [7:0] sid, input logic [15:0] addr,
			input logic [31:0] wv, input logic [7:0] rb);
		logic [7:0]        frame [13];
		logic [15:0]       crc;
		logic [RCNT_W-1:0] cap;
		logic [31:0]       val;
		status_t           st;
		int                len;
		int                i;
		case (c) inside
			CMD_READ, CMD_WRITE: begin
				frame[0]  = sid;
				frame[1]  = (c == CMD_WRITE) ? FUNC_WRITE : FUNC_READ;
				frame[2]  = addr[15:8];
				frame[3]  = addr[7:0];
				frame[4]  = 8'h00;
				frame[5]  = REG_COUNT;
				frame[6]  = BYTE_COUNT;
				frame[7]  = wv[31:24];
				frame[8]  = wv[23:16];
				frame[9]  = wv[15:8];
				frame[10] = wv[7:0];
				len = (c == CMD_WRITE) ? 11 : 6;
				crc = CRC_INIT;
				for (i = 0; i < len; i++) begin
					crc = crc16_add(crc, frame[i]);
				end
				frame[len]     = crc[7:0];
				frame[len + 1] = crc[15:8];
				len += 2;
				for (i = 0; i < len; i++) begin
					owed_results.push_back('{KIND_TX, frame[i], i == len - 1, ST_OK, 32'd0});
				end
				write_txn = (c == CMD_WRITE);
				rx_count  = '0;
				rx_crc    = CRC_INIT;
				rx_tail   = '0;
				rx_func   = '0;
				rx_word   = '0;
			end
			CMD_RX_BYTE: begin
				cap = write_txn ? WRITE_CAP : RCNT_W'(MAX_READ_RESPONSE);
				// drop bytes past the cap
				if (rx_count < cap) begin
					// the CRC trails two bytes behind, so the tail holds the received check
					if (rx_count >= 2) begin
						rx_crc = crc16_add(rx_crc, rx_tail[15:8]);
					end
					rx_tail = {rx_tail[7:0], rb};
					if (rx_count == 1) begin
						rx_func = rb;
					end
					if (rx_count >= 3 && rx_count <= 6) begin
						rx_word = {rx_word[23:0], rb};
					end
					rx_count = rx_count + 1'b1;
				end
			end
			default: begin
				val = '0;
				if (write_txn) begin
					if (rx_count < WRITE_CAP) begin
						st = ST_SHORT;
					end else if (rx_func != FUNC_WRITE) begin
						st = ST_NO_ACK;
					end else begin
						st = ST_OK;
					end
				end else begin
					if (rx_count < READ_MIN) begin
						st = ST_SHORT;
					end else if (rx_tail != {rx_crc[7:0], rx_crc[15:8]}) begin
						st = ST_CRC_BAD;
					end else begin
						st  = ST_OK;
						val = rx_word;
					end
				end
				owed_results.push_back('{KIND_VERDICT, 8'h00, 1'b1, st, val});
			end
		endcase
	endtask

	initial begin
		pending  = 0;
		failures = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		framer_beat_t got;
		framer_beat_t want;
		if (!arst_n) begin
			owed_results.delete();
			write_txn = 1'b0;
			rx_count  = '0;
			rx_crc    = CRC_INIT;
			rx_tail   = '0;
			rx_func   = '0;
			rx_word   = '0;
			failures  = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = '{result_kind_t'(result_ch.result_kind), result_ch.tx_byte,
					result_ch.tx_last, status_t'(result_ch.status), result_ch.read_value};
				if (owed_results.size() == 0) begin
					failures++;
					$display("%0t: result beat with none owed: kind %0d byte %02h last %0d status %0d value %08h",
						$time, got.kind, got.tx_byte, got.tx_last, got.status, got.read_value);
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						failures++;
						$display("%0t: result mismatch", $time);
						$display("  expected kind %0d byte %02h last %0d status %0d value %08h",
							want.kind, want.tx_byte, want.tx_last, want.status, want.read_value);
						$display("  actual   kind %0d byte %02h last %0d status %0d value %08h",
							got.kind, got.tx_byte, got.tx_last, got.status, got.read_value);
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				apply_command(cmd_t'(item_ch.cmd), item_ch.unit_id, item_ch.reg_address,
					item_ch.write_value, item_ch.rx_byte);
			end
		end
		pending = owed_results.size();
	end

endmodule

[bench/tb_top.sv]
// Top of the framer bench: clock, reset, command stimulus and result back-pressure.
// Depends on mbrtu_pkg, the channel interfaces, the framer and mbrtu_frame_monitor.
module tb_top;
	import mbrtu_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PHASE_ITEMS  = 106;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned pending;
	int unsigned failures;
	int unsigned items_sent = 0;
	int unsigned idle_pct   = 0;
	int unsigned stall_pct  = 0;
	int unsigned hold_left  = 0;
	logic        hold_req   = 1'b0;
	logic [7:0]  reply_bytes[$];

	mbrtu_item_if   cmd_ch();
	mbrtu_result_if res_ch();

	modbus_rtu_word_transaction_framer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_ch),
		.result (res_ch)
	);

	mbrtu_frame_monitor frame_mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (cmd_ch),
		.result_ch (res_ch),
		.pending   (pending),
		.failures  (failures)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Result back-pressure; a long hold-off is counted down here.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			res_ch.ready = 1'b0;
			hold_left--;
		end else begin
			res_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	// Offer one beat, hold it until taken, return at the next falling edge.
	task automatic offer(input cmd_t c, input logic [7:0] sid, input logic [15:0] addr,
			input logic [31:0] wv, input logic [7:0] rb);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid       = 1'b1;
		cmd_ch.cmd         = c;
		cmd_ch.unit_id     = sid;
		cmd_ch.reg_address = addr;
		cmd_ch.write_value = wv;
		cmd_ch.rx_byte     = rb;
		@(posedge clk);
		while (!cmd_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_request(input cmd_t c, input logic [7:0] sid, input logic [15:0] addr,
			input logic [31:0] wv);
		offer(c, sid, addr, wv, 8'($urandom));
	endtask

	task automatic send_rx(input logic [7:0] rb);
		offer(CMD_RX_BYTE, 8'($urandom), 16'($urandom), $urandom, rb);
	endtask

	task automatic send_close();
		offer(CMD_CLOSE, 8'($urandom), 16'($urandom), $urandom, 8'($urandom));
	endtask

	task automatic add_crc();
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (reply_bytes[i]) begin
			c = crc_next(c, reply_bytes[i]);
		end
		reply_bytes.push_back(c[7:0]);
		reply_bytes.push_back(c[15:8]);
	endtask

	task automatic flush_reply();
		foreach (reply_bytes[i]) begin
			send_rx(reply_bytes[i]);
		end
		reply_bytes.delete();
	endtask

	// Mostly one request, a reply that is mostly well formed, then usually the window close.
	task automatic run_transaction();
		int unsigned pick;
		int unsigned mode;
		int          idx;
		logic        wr;
		logic [7:0]  sid;
		logic [15:0] addr;
		logic [31:0] word;
		pick = $urandom_range(99);
		if (pick < 8) begin
			offer(cmd_t'(2'($urandom_range(3))), 8'($urandom), 16'($urandom), $urandom,
				8'($urandom));
			return;
		end
		wr   = (pick < 48);
		sid  = 8'($urandom);
		addr = 16'($urandom);
		word = $urandom;
		if ($urandom_range(9) == 0) begin
			word = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		end
		send_request(wr ? CMD_WRITE : CMD_READ, sid, addr, word);
		if (wr) begin
			reply_bytes = {sid, FUNC_WRITE, addr[15:8], addr[7:0], 8'h00, REG_COUNT};
		end else begin
			reply_bytes = {sid, FUNC_READ, BYTE_COUNT, word[31:24], word[23:16], word[15:8],
				word[7:0]};
		end
		add_crc();
		mode = $urandom_range(99);
		if (wr && mode < 6) begin
			// exception reply from the device
			reply_bytes[1] = FUNC_WRITE | 8'h80;
		end else if (mode < 16) begin
			idx = $urandom_range(reply_bytes.size() - 1);
			reply_bytes[idx] = reply_bytes[idx] ^ 8'(1 << $urandom_range(7));
		end else if (mode < 26) begin
			idx = $urandom_range(reply_bytes.size() - 1);
			while (reply_bytes.size() > idx) begin
				void'(reply_bytes.pop_back());
			end
		end else if (mode < 34) begin
			repeat ($urandom_range(30, 1)) reply_bytes.push_back(8'($urandom));
		end else if (mode < 38) begin
			reply_bytes.delete();
			repeat ($urandom_range(12)) reply_bytes.push_back(8'($urandom));
		end
		flush_reply();
		mode = $urandom_range(19);
		// now and then leave the window open
		if (mode != 0) begin
			send_close();
		end
		if (mode == 1) begin
			send_close();
		end
		if (mode == 2) begin
			send_rx(8'($urandom));
			send_close();
		end
	endtask

	task automatic run_until(input int unsigned target);
		while (items_sent < target) begin
			run_transaction();
		end
	endtask

	task automatic wait_drained();
		cmd_ch.valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.cmd         = CMD_READ;
		cmd_ch.unit_id     = '0;
		cmd_ch.reg_address = '0;
		cmd_ch.write_value = '0;
		cmd_ch.rx_byte     = '0;
		res_ch.ready       = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// close with no request made yet
		send_close();
		// read of device 0 at address 0 with a clean reply
		send_request(CMD_READ, 8'h00, 16'h0000, $urandom);
		reply_bytes = {8'h00, FUNC_READ, BYTE_COUNT, 8'hFF, 8'h00, 8'hA5, 8'h5A};
		add_crc();
		flush_reply();
		send_close();
		// write of all ones to device 255 at the top address, acknowledged plus one surplus byte
		send_request(CMD_WRITE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		reply_bytes = {8'hFF, FUNC_WRITE, 8'hFF, 8'hFF, 8'h00, REG_COUNT};
		add_crc();
		reply_bytes.push_back(8'h3C);
		flush_reply();
		send_close();
		send_close();
		send_rx(8'hC3);
		send_close();

		// no idling, opened by a long hold-off on the result side
		hold_req = 1'b1;
		run_until(items_sent + PHASE_ITEMS);
		idle_pct = 67;
		run_until(items_sent + PHASE_ITEMS);
		wait_drained();
		idle_pct  = 0;
		stall_pct = 67;
		run_until(items_sent + PHASE_ITEMS);
		idle_pct  = 15;
		stall_pct = 15;
		run_until(items_sent + PHASE_ITEMS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
